>>> hw/rtl/sats_pkg.sv
// sats_pkg: shared types and constants for the sleep aware task scheduler
// item structs, request codes, register indexes and field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sats_pkg;

  localparam int unsigned TASK_IDX_W = 5;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  // bytes reserved below each stack top for the initial frame
  localparam logic [WORD_W-1:0] FRAME_BYTES = 32'd136;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SLEEP = 2'd1,
    REQ_START = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 1'd0,
    REG_POLICY_MODE = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] saved_sp;
    logic [WORD_W-1:0] sleep_period;
  } sats_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]     next_sp;
    logic [TASK_IDX_W-1:0] task_index;
    logic [WORD_W-1:0]     wake_slice;
    logic                  none_ready;
  } sats_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/sats_next.sv
// sats_next: successor and highest-enabled-task search over the enable mask
// purely combinational, shared by every step of the scheduler walk
// depends on nothing beyond its parameter
`timescale 1ns / 1ps
`default_nettype none

module sats_next #(
  parameter int unsigned NUM_TASKS = 32,
  parameter int unsigned TW        = $clog2(NUM_TASKS)
) (
  input  wire logic [NUM_TASKS-1:0] live,
  input  wire logic                 prio_mode,
  input  wire logic [TW-1:0]        idx,
  output logic      [TW-1:0]        succ,
  output logic      [TW-1:0]        top
);

  logic found_up, found_dn, found_top;
  logic [TW-1:0] up_idx, dn_idx;

  // next higher enabled task
  always_comb begin
    found_up = 1'b0;
    up_idx   = '0;
    for (int k = 0; k < int'(NUM_TASKS); k++) begin
      if (!found_up && live[k] && (k > int'(idx))) begin
        found_up = 1'b1;
        up_idx   = TW'(k);
      end
    end
  end

  // next lower enabled task
  always_comb begin
    found_dn = 1'b0;
    dn_idx   = '0;
    for (int k = int'(NUM_TASKS) - 1; k >= 0; k--) begin
      if (!found_dn && live[k] && (k < int'(idx))) begin
        found_dn = 1'b1;
        dn_idx   = TW'(k);
      end
    end
  end

  // highest enabled task above task 0
  always_comb begin
    found_top = 1'b0;
    top       = '0;
    for (int k = int'(NUM_TASKS) - 1; k > 0; k--) begin
      if (!found_top && live[k]) begin
        found_top = 1'b1;
        top       = TW'(k);
      end
    end
  end

  always_comb begin
    if (!live[idx]) begin
      succ = '0;
    end else if (prio_mode) begin
      succ = dn_idx;
    end else begin
      succ = up_idx;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sleep_aware_task_scheduler.sv
// sleep_aware_task_scheduler: round robin / priority task scheduler with sleep
// holds stack and wake tables, walks successors one task per cycle
// depends on sats_pkg and sats_next
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                          | direction
// ----------+--------------------------------+----------
// input     | in_valid, in_ready, in_item    | in
// result    | out_valid, out_ready, out_item | out
// config    | cfg_we, cfg_index, cfg_wdata   | in
//
// one item at a time; in_ready is high only while the sequencer is idle
// tick: a save step picks the first candidate, then one candidate checked per
//   cycle (up to NUM_TASKS), then the final table read, which sleep and start
//   reach via their own state, unused codes directly; every table access is one
//   registered memory read, so the walk is bounded by the wake table port
// reset: synchronous, clears state and valid bits, no clear pass
// a held result stalls the sequencer in its last state until out_ready

module sleep_aware_task_scheduler
  import sats_pkg::*;
#(
  parameter int unsigned NUM_TASKS    = 32,
  parameter logic [31:0] STACK_TOP    = 32'd131068,
  parameter logic [31:0] STACK_STRIDE = 32'd256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sats_in_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sats_out_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  localparam int unsigned TW = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_SAVE,
    ST_WALK,
    ST_SLEEP,
    ST_START,
    ST_FIN_RD,
    ST_FIN
  } state_t;

  // control and configuration
  state_t              state_r, state_nxt;
  logic [WORD_W-1:0]   mask_r;
  logic                mode_r;
  logic [TW-1:0]       cur_r, cur_nxt;
  logic [WORD_W-1:0]   slice_r, slice_nxt;
  logic [TW-1:0]       cand_r, cand_nxt;
  logic [TW-1:0]       cnt_r, cnt_nxt;
  logic                flag_r, flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  sats_out_t           out_item_r, out_item_nxt;

  // latched item payload
  logic [WORD_W-1:0]   sp_r;
  logic [WORD_W-1:0]   period_r;

  // tables with per-entry valid bits for reset values
  logic [WORD_W-1:0]    stack_mem [NUM_TASKS];
  logic [WORD_W-1:0]    wake_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0] stack_vld_r, stack_vld_nxt;
  logic [NUM_TASKS-1:0] wake_vld_r, wake_vld_nxt;
  logic [WORD_W-1:0]    stack_q_r, wake_q_r;
  logic                 stack_qv_r, wake_qv_r;
  logic [TW-1:0]        rd_addr, rd_addr_r;

  logic                 stack_we, wake_we;
  logic [TW-1:0]        stack_wa, wake_wa;
  logic [WORD_W-1:0]    stack_wd, wake_wd;

  logic [WORD_W-1:0]    stack_eff, wake_eff, stack_dflt;
  logic [NUM_TASKS-1:0] live;
  logic [TW-1:0]        nx_idx, nx_succ, nx_top;
  logic                 cand_ready;
  logic                 in_acc;

  assign live   = mask_r[NUM_TASKS-1:0];
  assign in_acc = in_valid && in_ready;

  // walk from the current task when saving, from the candidate while walking
  assign nx_idx = (state_r == ST_WALK) ? cand_r : cur_r;

  sats_next #(
    .NUM_TASKS (NUM_TASKS),
    .TW        (TW)
  ) u_next (
    .live      (live),
    .prio_mode (mode_r),
    .idx       (nx_idx),
    .succ      (nx_succ),
    .top       (nx_top)
  );

  // entries never written read as their reset value
  assign stack_dflt = STACK_TOP - STACK_STRIDE * WORD_W'(rd_addr_r) - FRAME_BYTES;
  assign stack_eff  = stack_qv_r ? stack_q_r : stack_dflt;
  assign wake_eff   = wake_qv_r ? wake_q_r : '0;
  assign cand_ready = (wake_eff <= slice_r);

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (wake_we) begin
      wake_mem[wake_wa] <= wake_wd;
    end
    stack_q_r <= stack_mem[rd_addr];
    wake_q_r  <= wake_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    slice_nxt     = slice_r;
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    stack_vld_nxt = stack_vld_r;
    wake_vld_nxt  = wake_vld_r;
    rd_addr       = cur_r;
    stack_we      = 1'b0;
    stack_wa      = cur_r;
    stack_wd      = sp_r;
    wake_we       = 1'b0;
    wake_wa       = cur_r;
    wake_wd       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          flag_nxt = 1'b0;
          case (in_item.req_type)
            REQ_TICK:  state_nxt = ST_TICK_SAVE;
            REQ_SLEEP: state_nxt = ST_SLEEP;
            REQ_START: state_nxt = ST_START;
            default:   state_nxt = ST_FIN_RD;
          endcase
        end
      end
      ST_TICK_SAVE: begin
        // wake slice of the current task is in the read register
        if (cand_ready) begin
          slice_nxt = slice_r + 32'd1;
        end
        stack_we                = 1'b1;
        stack_vld_nxt[cur_r]    = 1'b1;
        cand_nxt                = mode_r ? nx_top : nx_succ;
        rd_addr                 = cand_nxt;
        cnt_nxt                 = '0;
        state_nxt               = ST_WALK;
      end
      ST_WALK: begin
        // one candidate per cycle against the updated slice count
        if (cand_ready || (cnt_r == TW'(NUM_TASKS - 1))) begin
          cur_nxt             = cand_ready ? cand_r : '0;
          flag_nxt            = !cand_ready;
          wake_we             = 1'b1;
          wake_wa             = cur_nxt;
          wake_wd             = '0;
          wake_vld_nxt[cur_nxt] = 1'b1;
          state_nxt           = ST_FIN_RD;
        end else begin
          cand_nxt = nx_succ;
          rd_addr  = nx_succ;
          cnt_nxt  = cnt_r + TW'(1);
        end
      end
      ST_SLEEP: begin
        wake_we              = 1'b1;
        wake_wd              = slice_r + period_r + 32'd1;
        wake_vld_nxt[cur_r]  = 1'b1;
        state_nxt            = ST_FIN_RD;
      end
      ST_START: begin
        // stack table back to defaults, wake table kept
        cur_nxt       = '0;
        slice_nxt     = '0;
        stack_vld_nxt = '0;
        state_nxt     = ST_FIN_RD;
      end
      ST_FIN_RD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.next_sp    = stack_eff;
          out_item_nxt.task_index = TASK_IDX_W'(cur_r);
          out_item_nxt.wake_slice = wake_eff;
          out_item_nxt.none_ready = flag_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= 32'd1;
      mode_r      <= 1'b0;
      cur_r       <= '0;
      slice_r     <= '0;
      cand_r      <= '0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      stack_vld_r <= '0;
      wake_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      slice_r     <= slice_nxt;
      cand_r      <= cand_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      stack_vld_r <= stack_vld_nxt;
      wake_vld_r  <= wake_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE_MASK: mask_r <= cfg_wdata;
          REG_POLICY_MODE: mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    rd_addr_r  <= rd_addr;
    stack_qv_r <= stack_vld_r[rd_addr];
    wake_qv_r  <= wake_vld_r[rd_addr];
    if (in_acc) begin
      sp_r     <= in_item.saved_sp;
      period_r <= in_item.sleep_period;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> tb/sleep_aware_task_scheduler_tb.sv
// sleep_aware_task_scheduler_tb: self-checking bench for the task scheduler
// drives ticks, sleeps and starts, predicts each result and compares fields
// depends on sats_pkg and sleep_aware_task_scheduler
`timescale 1ns / 1ps

module sleep_aware_task_scheduler_tb;
  import sats_pkg::*;

  localparam int unsigned NTASK = 32;
  localparam logic [31:0] TOP = 32'd131068;
  localparam logic [31:0] STRIDE = 32'd256;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 480;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sats_in_t in_item;
  logic out_valid;
  logic out_ready;
  sats_out_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  sleep_aware_task_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // scheduler shadow state
  logic [31:0] sh_mask;
  logic        sh_prio;
  logic [31:0] sh_stack [NTASK];
  logic [31:0] sh_wake [NTASK];
  logic [4:0]  sh_cur;
  logic [31:0] sh_slice;

  sats_out_t sched_q[$];
  int unsigned n_err;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_none;
  int unsigned idle_cycles;
  bit          quiet;

  function automatic logic [31:0] default_sp(int unsigned i);
    return TOP - STRIDE * i - FRAME_BYTES;
  endfunction

  function automatic logic [4:0] next_task(logic [4:0] i);
    if (!sh_mask[i]) return 5'd0;
    if (!sh_prio) begin
      for (int j = int'(i) + 1; j < NTASK; j++)
        if (sh_mask[j]) return 5'(j);
      return 5'd0;
    end
    for (int j = int'(i) - 1; j >= 0; j--)
      if (sh_mask[j]) return 5'(j);
    return 5'd0;
  endfunction

  function automatic logic [4:0] top_task();
    for (int j = NTASK - 1; j > 0; j--)
      if (sh_mask[j]) return 5'(j);
    return 5'd0;
  endfunction

  task automatic sched_reset();
    sh_mask = 32'd1;
    sh_prio = 1'b0;
    for (int i = 0; i < NTASK; i++) begin
      sh_stack[i] = default_sp(i);
      sh_wake[i] = '0;
    end
    sh_cur = '0;
    sh_slice = '0;
  endtask

  // advance the shadow by one item and return what the block should report
  function automatic sats_out_t sched_step(sats_in_t it);
    sats_out_t r;
    logic [4:0] cand;
    bit found;
    found = 0;
    r.none_ready = 1'b0;
    case (req_t'(it.req_type))
      REQ_TICK: begin
        if (sh_wake[sh_cur] <= sh_slice) sh_slice = sh_slice + 1;
        sh_stack[sh_cur] = it.saved_sp;
        cand = sh_prio ? top_task() : next_task(sh_cur);
        for (int n = 0; n < NTASK; n++) begin
          if (sh_wake[cand] <= sh_slice) begin
            found = 1;
            break;
          end
          cand = next_task(cand);
        end
        if (!found) begin
          cand = '0;
          r.none_ready = 1'b1;
        end
        sh_cur = cand;
        sh_wake[cand] = '0;
      end
      REQ_SLEEP: sh_wake[sh_cur] = sh_slice + it.sleep_period + 1;
      REQ_START: begin
        sh_cur = '0;
        sh_slice = '0;
        for (int i = 0; i < NTASK; i++) sh_stack[i] = default_sp(i);
      end
      default: ;
    endcase
    r.next_sp = sh_stack[sh_cur];
    r.task_index = sh_cur;
    r.wake_slice = sh_wake[sh_cur];
    return r;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
      if (out_valid && out_ready) begin
        n_out++;
        if (sched_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %p", out_item);
        end else begin
          automatic sats_out_t e = sched_q.pop_front();
          if (e.none_ready) n_none++;
          if (out_item.next_sp !== e.next_sp || out_item.task_index !== e.task_index ||
              out_item.wake_slice !== e.wake_slice ||
              out_item.none_ready !== e.none_ready) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch exp sp=%h task=%0d wake=%h none=%b act sp=%h task=%0d wake=%h none=%b",
                       e.next_sp, e.task_index, e.wake_slice, e.none_ready,
                       out_item.next_sp, out_item.task_index, out_item.wake_slice,
                       out_item.none_ready);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ENABLE_MASK) sh_mask = val;
    else sh_prio = val[0];
    @(posedge clk);
  endtask

  // let the block drain before touching its registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (NTASK + 8) @(posedge clk);
  endtask

  // push one item; the prediction is made at acceptance, with a random gap first
  task automatic send_item(sats_in_t it, output sats_out_t pred);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = sched_step(it);
    sched_q.push_back(pred);
    n_in++;
  endtask

  function automatic sats_in_t mk(req_t rq, logic [31:0] sp, logic [31:0] per);
    sats_in_t it;
    it.req_type = rq;
    it.saved_sp = sp;
    it.sleep_period = per;
    return it;
  endfunction

  // directed rows: item, optional typed-in expectation
  typedef struct {
    sats_in_t  it;
    bit        has_exp;
    sats_out_t exp;
  } row_t;

  row_t rows[$];

  task automatic add_row(sats_in_t it, bit has, logic [31:0] sp, logic [4:0] tk,
                         logic [31:0] wk, logic nr);
    row_t r;
    r.it = it;
    r.has_exp = has;
    r.exp = '{next_sp: sp, task_index: tk, wake_slice: wk, none_ready: nr};
    rows.push_back(r);
  endtask

  task automatic run_rows();
    sats_out_t p;
    foreach (rows[k]) begin
      send_item(rows[k].it, p);
      if (rows[k].has_exp && p !== rows[k].exp) begin
        n_err++;
        if (n_err <= 10) $display("row %0d table exp %p pred %p", k, rows[k].exp, p);
      end
    end
    rows.delete();
  endtask

  function automatic sats_in_t rand_item();
    sats_in_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) it.req_type = REQ_TICK;
    else if (pick < 88) it.req_type = REQ_SLEEP;
    else if (pick < 95) it.req_type = REQ_START;
    else it.req_type = REQ_NONE;
    it.saved_sp = $urandom();
    // mostly short sleeps so tasks wake again; some huge ones for wrap
    case ($urandom_range(9))
      0: it.sleep_period = $urandom();
      1: it.sleep_period = 32'hFFFF_FFFF - $urandom_range(3);
      default: it.sleep_period = $urandom_range(6);
    endcase
    return it;
  endfunction

  logic [31:0] masks [6];
  sats_out_t   dummy;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_err = 0; n_in = 0; n_out = 0; n_none = 0;
    idle_cycles = 0;
    quiet = 0;
    sched_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset only task 0 exists: ticks stay on it
    add_row(mk(REQ_TICK, 32'hFFFF_FFFF, '0), 1, 32'hFFFF_FFFF, 5'd0, '0, 1'b0);
    add_row(mk(REQ_START, '0, '0), 1, TOP - FRAME_BYTES, 5'd0, '0, 1'b0);
    add_row(mk(REQ_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A), 1, TOP - FRAME_BYTES, 5'd0,
            '0, 1'b0);
    // sleep task 0 with all ones: wake slice wraps to slice
    add_row(mk(REQ_SLEEP, '0, 32'hFFFF_FFFF), 1, TOP - FRAME_BYTES, 5'd0, 32'd0, 1'b0);
    add_row(mk(REQ_SLEEP, '0, 32'd0), 1, TOP - FRAME_BYTES, 5'd0, 32'd1, 1'b0);
    // only sleeping task: the walk gives up on task 0
    add_row(mk(REQ_TICK, 32'h0000_0000, '0), 1, 32'h0, 5'd0, '0, 1'b1);
    run_rows();

    wait_drained();
    write_reg(REG_ENABLE_MASK, 32'hFFFF_FFFF);
    write_reg(REG_POLICY_MODE, 32'd0);
    // round robin upward from task 0, putting two of the visited tasks to sleep
    add_row(mk(REQ_START, '0, '0), 1, TOP - FRAME_BYTES, 5'd0, '0, 1'b0);
    add_row(mk(REQ_TICK, 32'h1234_5678, '0), 1, TOP - STRIDE - FRAME_BYTES, 5'd1, '0, 1'b0);
    add_row(mk(REQ_SLEEP, '0, 32'd3), 0, '0, '0, '0, 1'b0);
    add_row(mk(REQ_TICK, 32'h8765_4321, '0), 0, '0, '0, '0, 1'b0);
    add_row(mk(REQ_SLEEP, '0, 32'hFFFF_FFFE), 0, '0, '0, '0, 1'b0);
    for (int k = 0; k < 6; k++) add_row(mk(REQ_TICK, $urandom(), '0), 0, '0, '0, '0, 1'b0);
    run_rows();

    wait_drained();
    write_reg(REG_POLICY_MODE, 32'd1);
    // priority mode starts at the top task
    add_row(mk(REQ_TICK, 32'hDEAD_BEEF, '0), 0, '0, '0, '0, 1'b0);
    add_row(mk(REQ_SLEEP, '0, 32'd10), 0, '0, '0, '0, 1'b0);
    add_row(mk(REQ_TICK, 32'h0, '0), 0, '0, '0, '0, 1'b0);
    add_row(mk(REQ_START, '0, '0), 0, '0, '0, '0, 1'b0);
    run_rows();

    // random phases over several register settings, extremes included
    masks[0] = 32'hFFFF_FFFF; masks[1] = 32'h0000_0000; masks[2] = 32'h8000_0001;
    masks[3] = 32'h0000_000F; masks[4] = 32'h5555_5555; masks[5] = 32'hAAAA_AAAA;
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      write_reg(REG_ENABLE_MASK, (ph < 6) ? masks[ph] : $urandom());
      write_reg(REG_POLICY_MODE, 32'(ph & 1));
      // one phase runs without any idling on either side
      quiet = (ph == 4);
      for (int k = 0; k < N_RANDOM / 12; k++) send_item(rand_item(), dummy);
      quiet = 0;
    end

    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (NTASK + 8) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d with no ready task",
             n_in, n_out, n_none);
    if (n_err == 0 && sched_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sats_pkg.sv
hw/rtl/sats_next.sv
hw/rtl/sleep_aware_task_scheduler.sv
tb/sleep_aware_task_scheduler_tb.sv
